@@ src/kpi_pkg.sv @@
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared types and codes of the keyframe position interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;

    localparam int DivW = 49;   // dividend width: 33-bit magnitude shifted by 16

    // Read address selects.
    localparam logic [3:0] RD_ZERO   = 4'd0;
    localparam logic [3:0] RD_LAST   = 4'd1;
    localparam logic [3:0] RD_CACHED = 4'd2;
    localparam logic [3:0] RD_KUP    = 4'd3;
    localparam logic [3:0] RD_KDN    = 4'd4;
    localparam logic [3:0] RD_CUP    = 4'd5;
    localparam logic [3:0] RD_CDN    = 4'd6;
    localparam logic [3:0] RD_PREV   = 4'd7;
    localparam logic [3:0] RD_NEXT   = 4'd8;

    // Key pair selects.
    localparam logic [2:0] PAIR_FIRST  = 3'd0;
    localparam logic [2:0] PAIR_LAST   = 3'd1;
    localparam logic [2:0] PAIR_CACHED = 3'd2;
    localparam logic [2:0] PAIR_FWD    = 3'd3;
    localparam logic [2:0] PAIR_BWD    = 3'd4;

    typedef struct packed {
        logic       take;       // an input item is accepted
        logic       query_ld;
        logic       clamp_c;
        logic       rd_en;
        logic [3:0] rd_sel;
        logic       pair_en;
        logic [2:0] pair_sel;
        logic       cap_prev;
        logic       cap_next;
        logic       div_start;
        logic       div_speed;
        logic       cap_frac;
        logic       mul_en;
        logic       add_en;
        logic       cap_speed;
        logic [1:0] axis;
        logic       publish;
    } kpi_cmd_t;

    typedef struct packed {
        logic is_query;
        logic t_le_rd;
        logic t_ge_rd;
        logic t_gt_rd;
        logic t_lt_rd;
        logic k_lt_last;
        logic k_gt0;
        logic collapsed;
        logic div_busy;
        logic out_busy;
    } kpi_stat_t;

endpackage

@@ src/kpi_div.sv @@
// ----------------------------------------------------------------------------
// kpi_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module kpi_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [kpi_pkg::DivW-1:0] dividend,
    input  logic [31:0]              divisor,
    output logic                     busy,
    output logic [kpi_pkg::DivW-1:0] quotient
);
    localparam int CntW = $clog2(kpi_pkg::DivW + 1);

    logic                     busy_reg;
    logic [CntW-1:0]          cnt_reg;
    logic [31:0]              rem_reg;
    logic [31:0]              dvs_reg;
    logic [kpi_pkg::DivW-1:0] quo_reg;
    logic [32:0]              trial;
    logic                     fits;

    assign trial = {rem_reg, quo_reg[kpi_pkg::DivW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CntW'(kpi_pkg::DivW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            quo_reg <= {quo_reg[kpi_pkg::DivW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

@@ src/kpi_ctrl.sv @@
// ----------------------------------------------------------------------------
// kpi_ctrl
// Sequencer: key search, fetch of the pair, division and interpolation steps.
// ----------------------------------------------------------------------------
module kpi_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  kpi_pkg::kpi_stat_t stat,
    output kpi_pkg::kpi_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK0  = 4'd1;
    localparam logic [3:0] S_CHKN  = 4'd2;
    localparam logic [3:0] S_CHKC  = 4'd3;
    localparam logic [3:0] S_FWD   = 4'd4;
    localparam logic [3:0] S_BWD   = 4'd5;
    localparam logic [3:0] S_RDP   = 4'd6;
    localparam logic [3:0] S_CAPP  = 4'd7;
    localparam logic [3:0] S_CAPN  = 4'd8;
    localparam logic [3:0] S_DIVF  = 4'd9;
    localparam logic [3:0] S_WAITF = 4'd10;
    localparam logic [3:0] S_MUL   = 4'd11;
    localparam logic [3:0] S_ADD   = 4'd12;
    localparam logic [3:0] S_DIVS  = 4'd13;
    localparam logic [3:0] S_WAITS = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.axis   = axis_reg;
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (stat.is_query) begin
                        cmd.query_ld = 1'b1;
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = kpi_pkg::RD_ZERO;
                        state_next   = S_CHK0;
                    end
                end
            end
            S_CHK0: begin
                cmd.clamp_c = 1'b1;
                if (stat.t_le_rd) begin
                    cmd.pair_en  = 1'b1;
                    cmd.pair_sel = kpi_pkg::PAIR_FIRST;
                    state_next   = S_RDP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kpi_pkg::RD_LAST;
                    state_next = S_CHKN;
                end
            end
            S_CHKN: begin
                if (stat.t_ge_rd) begin
                    cmd.pair_en  = 1'b1;
                    cmd.pair_sel = kpi_pkg::PAIR_LAST;
                    state_next   = S_RDP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kpi_pkg::RD_CACHED;
                    state_next = S_CHKC;
                end
            end
            S_CHKC: begin
                if (stat.t_gt_rd) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kpi_pkg::RD_CUP;
                    state_next = S_FWD;
                end else if (stat.t_lt_rd) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kpi_pkg::RD_CDN;
                    state_next = S_BWD;
                end else begin
                    cmd.pair_en  = 1'b1;
                    cmd.pair_sel = kpi_pkg::PAIR_CACHED;
                    state_next   = S_RDP;
                end
            end
            S_FWD: begin
                if (stat.k_lt_last && stat.t_ge_rd) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kpi_pkg::RD_KUP;
                end else begin
                    cmd.pair_en  = 1'b1;
                    cmd.pair_sel = kpi_pkg::PAIR_FWD;
                    state_next   = S_RDP;
                end
            end
            S_BWD: begin
                if (stat.k_gt0 && stat.t_le_rd) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kpi_pkg::RD_KDN;
                end else begin
                    cmd.pair_en  = 1'b1;
                    cmd.pair_sel = kpi_pkg::PAIR_BWD;
                    state_next   = S_RDP;
                end
            end
            S_RDP: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = kpi_pkg::RD_PREV;
                state_next = S_CAPP;
            end
            S_CAPP: begin
                cmd.cap_prev = 1'b1;
                if (stat.collapsed) begin
                    state_next = S_OUT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kpi_pkg::RD_NEXT;
                    state_next = S_CAPN;
                end
            end
            S_CAPN: begin
                cmd.cap_next = 1'b1;
                state_next   = S_DIVF;
            end
            S_DIVF: begin
                cmd.div_start = 1'b1;
                state_next    = S_WAITF;
            end
            S_WAITF: begin
                if (!stat.div_busy) begin
                    cmd.cap_frac = 1'b1;
                    axis_next    = 2'd0;
                    state_next   = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add_en = 1'b1;
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    state_next = S_DIVS;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DIVS: begin
                cmd.div_start = 1'b1;
                cmd.div_speed = 1'b1;
                state_next    = S_WAITS;
            end
            S_WAITS: begin
                cmd.div_speed = 1'b1;
                if (!stat.div_busy) begin
                    cmd.cap_speed = 1'b1;
                    if (axis_reg == 2'd2) begin
                        state_next = S_OUT;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DIVS;
                    end
                end
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

@@ src/kpi_dpath.sv @@
// ----------------------------------------------------------------------------
// kpi_dpath
// Key table, search registers, divider, multiplier and the output register.
// ----------------------------------------------------------------------------
module kpi_dpath #(
    parameter int MAX_KEYS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  kpi_pkg::kpi_cmd_t  cmd,
    output kpi_pkg::kpi_stat_t stat,
    input  logic               s_tuser,
    input  logic [167:0]       s_tdata,
    input  logic               cfg_valid,
    input  logic [6:0]         cfg_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [223:0]       m_tdata
);
    localparam int IW = $clog2(MAX_KEYS);

    logic [127:0] mem [MAX_KEYS];
    logic [127:0] rd_q;
    logic [IW-1:0] rd_addr;
    logic [31:0]  rd_time;

    logic [6:0]    kc_reg;
    logic [31:0]   t_reg;
    logic [IW-1:0] last_reg, c_reg, k_reg, prev_reg, next_reg;
    logic [31:0]   tp_reg, tn_reg;
    logic [31:0]   pp_reg [3];
    logic [31:0]   pn_reg [3];
    logic [15:0]   frac_reg;
    logic [31:0]   pos_reg [3];
    logic [31:0]   spd_reg [3];
    logic signed [49:0] prod_reg;

    logic          out_valid_reg;
    logic [223:0]  out_data_reg;

    logic [31:0]   idx_w, kc_w;
    logic [IW-1:0] last_new;
    logic [31:0]   dt, num;
    logic          dt_zero;
    logic signed [32:0] dx;
    logic [32:0]   mag;
    logic [kpi_pkg::DivW-1:0] dividend, quotient;
    logic          div_busy;
    logic [31:0]   q_sat;

    // Load items write the table directly.
    assign idx_w = 32'(s_tdata[5:0]);
    always_ff @(posedge aclk) begin
        if (cmd.take && !s_tuser && idx_w < 32'(MAX_KEYS)) begin
            mem[IW'(s_tdata[5:0])] <= s_tdata[133:6];
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            kpi_pkg::RD_ZERO:   rd_addr = '0;
            kpi_pkg::RD_LAST:   rd_addr = last_reg;
            kpi_pkg::RD_CACHED: rd_addr = c_reg;
            kpi_pkg::RD_KUP:    rd_addr = k_reg + 1'b1;
            kpi_pkg::RD_KDN:    rd_addr = k_reg - 1'b1;
            kpi_pkg::RD_CUP:    rd_addr = c_reg + 1'b1;
            kpi_pkg::RD_CDN:    rd_addr = c_reg - 1'b1;
            kpi_pkg::RD_PREV:   rd_addr = prev_reg;
            kpi_pkg::RD_NEXT:   rd_addr = next_reg;
            default:            rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end
    assign rd_time = rd_q[31:0];

    // Key count held to 1..MAX_KEYS, kept as the index of the last key.
    assign kc_w = 32'(kc_reg);
    always_comb begin
        if (kc_w == 32'd0) begin
            last_new = '0;
        end else if (kc_w > 32'(MAX_KEYS)) begin
            last_new = IW'(MAX_KEYS - 1);
        end else begin
            last_new = IW'(kc_w - 32'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kc_reg <= 7'd1;
            c_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                kc_reg <= cfg_data;
            end
            if (cmd.pair_en) begin
                case (cmd.pair_sel)
                    kpi_pkg::PAIR_FIRST: c_reg <= '0;
                    kpi_pkg::PAIR_LAST:  c_reg <= last_reg;
                    kpi_pkg::PAIR_FWD:   c_reg <= k_reg - 1'b1;
                    kpi_pkg::PAIR_BWD:   c_reg <= k_reg + 1'b1;
                    default:             c_reg <= c_reg;
                endcase
            end else if (cmd.clamp_c && c_reg > last_reg) begin
                c_reg <= last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.query_ld) begin
            t_reg    <= s_tdata[165:134];
            last_reg <= last_new;
        end
        if (cmd.rd_en) begin
            k_reg <= rd_addr;
        end
        if (cmd.pair_en) begin
            case (cmd.pair_sel)
                kpi_pkg::PAIR_FIRST: begin
                    prev_reg <= '0;
                    next_reg <= '0;
                end
                kpi_pkg::PAIR_LAST: begin
                    prev_reg <= last_reg;
                    next_reg <= last_reg;
                end
                kpi_pkg::PAIR_FWD: begin
                    prev_reg <= k_reg - 1'b1;
                    next_reg <= k_reg;
                end
                kpi_pkg::PAIR_BWD: begin
                    prev_reg <= k_reg;
                    next_reg <= k_reg + 1'b1;
                end
                default: begin
                    prev_reg <= c_reg;
                    next_reg <= c_reg;
                end
            endcase
        end
        if (cmd.cap_prev) begin
            tp_reg    <= rd_q[31:0];
            pp_reg[0] <= rd_q[63:32];
            pp_reg[1] <= rd_q[95:64];
            pp_reg[2] <= rd_q[127:96];
        end
        if (cmd.cap_next) begin
            tn_reg    <= rd_q[31:0];
            pn_reg[0] <= rd_q[63:32];
            pn_reg[1] <= rd_q[95:64];
            pn_reg[2] <= rd_q[127:96];
        end
    end

    // Segment arithmetic.
    assign dt_zero = (tn_reg <= tp_reg);
    assign dt      = dt_zero ? 32'd0 : tn_reg - tp_reg;
    assign num     = (t_reg < tp_reg) ? 32'd0 : t_reg - tp_reg;
    assign dx      = $signed({pn_reg[cmd.axis][31], pn_reg[cmd.axis]})
                   - $signed({pp_reg[cmd.axis][31], pp_reg[cmd.axis]});
    assign mag     = dx[32] ? 33'(-dx) : 33'(dx);
    assign dividend = cmd.div_speed ? {mag, 16'd0} : {1'b0, num, 16'd0};

    kpi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (dt),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb begin
        if (dx[32]) begin
            q_sat = (quotient > kpi_pkg::DivW'(32'h8000_0000))
                  ? 32'h8000_0000 : quotient[31:0];
            q_sat = 32'(~q_sat + 32'd1);
        end else begin
            q_sat = (quotient > kpi_pkg::DivW'(32'h7FFF_FFFF))
                  ? 32'h7FFF_FFFF : quotient[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_frac) begin
            if (dt_zero) begin
                frac_reg <= '0;
            end else if (quotient > kpi_pkg::DivW'(16'hFFFF)) begin
                frac_reg <= 16'hFFFF;
            end else begin
                frac_reg <= quotient[15:0];
            end
        end
        if (cmd.mul_en) begin
            prod_reg <= dx * $signed({1'b0, frac_reg}) + 50'sd32768;
        end
        if (cmd.add_en) begin
            pos_reg[cmd.axis] <= pp_reg[cmd.axis] + prod_reg[47:16];
        end
        if (cmd.cap_speed) begin
            spd_reg[cmd.axis] <= dt_zero ? 32'd0 : q_sat;
        end
    end

    // Output register: the next item may enter while this one waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            if (prev_reg == next_reg) begin
                out_data_reg <= {3'd0, 1'b1, 16'd0, 6'(next_reg), 6'(prev_reg),
                                 96'd0, pp_reg[2], pp_reg[1], pp_reg[0]};
            end else begin
                out_data_reg <= {3'd0, 1'b0, frac_reg, 6'(next_reg), 6'(prev_reg),
                                 spd_reg[2], spd_reg[1], spd_reg[0],
                                 pos_reg[2], pos_reg[1], pos_reg[0]};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat.is_query  = s_tuser;
    assign stat.t_le_rd   = t_reg <= rd_time;
    assign stat.t_ge_rd   = t_reg >= rd_time;
    assign stat.t_gt_rd   = t_reg > rd_time;
    assign stat.t_lt_rd   = t_reg < rd_time;
    assign stat.k_lt_last = k_reg < last_reg;
    assign stat.k_gt0     = k_reg != '0;
    assign stat.collapsed = prev_reg == next_reg;
    assign stat.div_busy  = div_busy;
    assign stat.out_busy  = out_valid_reg && !m_tready;
endmodule

@@ src/keyframe_position_interpolator.sv @@
// ----------------------------------------------------------------------------
// keyframe_position_interpolator
// Linear position interpolation over a table of key frames.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser is the mode (0 loads a key, 1 queries a time).
// A load item writes one slot of the key table in its accept cycle and gives
// no result. A query item walks from the cached key to the key pair around
// the query time (one table read per cycle), then runs a bit-serial divider
// for the fraction and for each speed axis, and a shared multiplier for the
// three positions. The four 49-step divisions take most of a query's time.
// A query at or before the first key, at or after the last key, or exactly
// on the cached key skips the divisions and returns the position of that key
// with clamped set and zero speed. One item is worked on at a time.
// Result channel m_*: an output register holds the result; the next item is
// accepted while it waits, and a query stalls only at its end when the
// register is still full. Configuration (cfg_*) sets key_count; cfg_ready is
// always high and writes belong to idle periods. Reset clears control, sets
// key_count to 1 and the cached key to 0; the key table is undefined until
// loaded.
// ----------------------------------------------------------------------------
module keyframe_position_interpolator #(
    parameter int MAX_KEYS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,   // mode
    // key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
    // key_z[133:102], query_time[165:134], zero fill
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], speed_x[127:96],
    // speed_y[159:128], speed_z[191:160], prev_key[197:192],
    // next_key[203:198], fraction[219:204], clamped[220], zero fill
    output logic [223:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data
);
    kpi_pkg::kpi_cmd_t  cmd;
    kpi_pkg::kpi_stat_t stat;

    assign cfg_ready = 1'b1;

    kpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kpi_dpath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
